// ===== src/fsrv_pkg.sv =====
// ----------------------------------------------------------------------------
// fsrv_pkg
// Shared types and constants for the font spec record validator.
// ----------------------------------------------------------------------------
package fsrv_pkg;

  // Record layout
  localparam logic [31:0] SPEC_VERSION = 32'd1;
  localparam logic [4:0]  HEADER_BYTES = 5'd20;
  localparam logic [4:0]  LENGTH_BYTES = 5'd4;

  // Byte offsets, counted after the byte, at which each header word completes
  localparam logic [4:0]  POS_VERSION   = 5'd4;
  localparam logic [4:0]  POS_SIZE_CODE = 5'd8;
  localparam logic [4:0]  POS_WEIGHT    = 5'd12;
  localparam logic [4:0]  POS_STYLE     = 5'd16;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_NAME   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // One result transaction
  typedef struct packed {
    logic        valid_res;
    logic [30:0] size_code;
    logic [31:0] weight;
    logic        style;
    logic [30:0] num_families;
  } result_t;

  // Word is positive as a signed 32-bit value
  function automatic logic positive32(input logic [31:0] w);
    return (w != 32'd0) && !w[31];
  endfunction

endpackage

// ===== src/font_spec_record_validator_core.sv =====
// ----------------------------------------------------------------------------
// font_spec_record_validator_core
// Byte-serial font spec record validator with one result per record.
// ----------------------------------------------------------------------------
// Throughput: one record byte per cycle while byte_stall is low, limited by the parser state update.
// A final byte passes through the input register, then the result register;
// its result is presented once loaded into the result register.
// The input register stalls only while it holds a final byte and the result
// register is occupied and stalled.
// Reset (rst, synchronous) empties both registers and clears the parser.
module font_spec_record_validator_core (
  input  logic        clk,
  input  logic        rst,
  // Byte channel
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_record,
  // Result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic        valid_res,
  output logic [30:0] size_code,
  output logic signed [31:0] weight,
  output logic        style,
  output logic [30:0] num_families
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_eor;
  logic              advance;
  logic              accept;
  fsrv_pkg::result_t parse_result;
  fsrv_pkg::result_t held;

  // Stage advance: only a final byte needs room in the result register
  assign advance    = s1_valid && (!s1_eor || !result_valid || !result_stall);
  assign byte_stall = s1_valid && !advance;
  assign accept     = byte_valid && !byte_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= data_byte;
      s1_eor  <= end_of_record;
    end
  end

  fsrv_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .fire          (advance),
    .data_byte     (s1_byte),
    .end_of_record (s1_eor),
    .result        (parse_result)
  );

  fsrv_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && s1_eor),
    .load_data    (parse_result),
    .full         (result_valid),
    .result_stall (result_stall),
    .held         (held)
  );

  assign valid_res    = held.valid_res;
  assign size_code    = held.size_code;
  assign weight       = held.weight;
  assign style        = held.style;
  assign num_families = held.num_families;

  // An invalid record reports all-zero header fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !valid_res) |->
      (size_code == 31'd0 && weight == 32'sd0 && !style && num_families == 31'd0))
    else $error("invalid result carries nonzero fields");

  // A valid record has a positive size code and family count
  a_valid_positive: assert property (@(posedge clk) disable iff (rst)
    (result_valid && valid_res) |-> (size_code != 31'd0 && num_families != 31'd0))
    else $error("valid result with zero size code or family count");

  // Backpressure reaches the input only through a blocked final byte
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> (s1_valid && s1_eor && result_valid && result_stall))
    else $error("byte channel stalled without a blocked final byte");

  // A blocked final byte is still held on the next cycle
  a_eor_held: assert property (@(posedge clk) disable iff (rst)
    byte_stall |=> (s1_valid && s1_eor))
    else $error("blocked final byte lost from input register");

endmodule

// ===== src/fsrv_parser.sv =====
// ----------------------------------------------------------------------------
// fsrv_parser
// Record parser state and its per-byte update; forms the result on the
// final byte and returns to the start state for the next record.
// ----------------------------------------------------------------------------
module fsrv_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              end_of_record,
  output fsrv_pkg::result_t result
);

  fsrv_pkg::phase_t phase, phase_next;
  logic [4:0]  byte_position, byte_position_next;
  logic [31:0] word_gather, word_gather_next;
  logic [30:0] header_size_code, header_size_code_next;
  logic [31:0] header_weight, header_weight_next;
  logic        header_style, header_style_next;
  logic [30:0] families_left, families_left_next;
  logic [30:0] family_total, family_total_next;
  logic [30:0] name_bytes_left, name_bytes_left_next;
  logic        error_seen, error_seen_next;

  logic [31:0] gathered;
  logic [4:0]  pos_inc;
  logic [30:0] names_dec;
  logic [30:0] families_dec;
  logic        ok;

  // Byte update
  always_comb begin
    phase_next            = phase;
    byte_position_next    = byte_position;
    word_gather_next      = word_gather;
    header_size_code_next = header_size_code;
    header_weight_next    = header_weight;
    header_style_next     = header_style;
    families_left_next    = families_left;
    family_total_next     = family_total;
    name_bytes_left_next  = name_bytes_left;
    error_seen_next       = error_seen;

    gathered     = {data_byte, word_gather[31:8]};
    pos_inc      = byte_position + 5'd1;
    names_dec    = name_bytes_left - 31'd1;
    families_dec = families_left - 31'd1;

    if (!error_seen) begin
      case (phase)
        fsrv_pkg::PH_HEADER: begin
          word_gather_next   = gathered;
          byte_position_next = pos_inc;
          if (pos_inc[1:0] == 2'd0) begin
            case (pos_inc)
              fsrv_pkg::POS_VERSION: begin
                if (gathered != fsrv_pkg::SPEC_VERSION) error_seen_next = 1'b1;
              end
              fsrv_pkg::POS_SIZE_CODE: begin
                header_size_code_next = gathered[30:0];
                if (!fsrv_pkg::positive32(gathered)) error_seen_next = 1'b1;
              end
              fsrv_pkg::POS_WEIGHT: begin
                header_weight_next = gathered;
              end
              fsrv_pkg::POS_STYLE: begin
                header_style_next = gathered[0];
                if (gathered > 32'd1) error_seen_next = 1'b1;
              end
              default: begin
                // family count word, last of the header
                if (!fsrv_pkg::positive32(gathered)) begin
                  error_seen_next = 1'b1;
                end else begin
                  family_total_next  = gathered[30:0];
                  families_left_next = gathered[30:0];
                  phase_next         = fsrv_pkg::PH_LENGTH;
                  byte_position_next = 5'd0;
                end
              end
            endcase
          end
        end
        fsrv_pkg::PH_LENGTH: begin
          word_gather_next   = gathered;
          byte_position_next = pos_inc;
          if (pos_inc == fsrv_pkg::LENGTH_BYTES) begin
            byte_position_next = 5'd0;
            if (!fsrv_pkg::positive32(gathered)) begin
              error_seen_next = 1'b1;
            end else begin
              name_bytes_left_next = gathered[30:0];
              phase_next           = fsrv_pkg::PH_NAME;
            end
          end
        end
        fsrv_pkg::PH_NAME: begin
          name_bytes_left_next = names_dec;
          if (names_dec == 31'd0) begin
            families_left_next = families_dec;
            phase_next = (families_dec == 31'd0) ? fsrv_pkg::PH_DONE
                                                 : fsrv_pkg::PH_LENGTH;
          end
        end
        default: begin
          // trailing byte after the last name
          error_seen_next = 1'b1;
        end
      endcase
    end
  end

  // Result from the updated state
  always_comb begin
    ok                  = !error_seen_next && (phase_next == fsrv_pkg::PH_DONE);
    result.valid_res    = ok;
    result.size_code    = ok ? header_size_code_next : 31'd0;
    result.weight       = ok ? header_weight_next : 32'd0;
    result.style        = ok ? header_style_next : 1'b0;
    result.num_families = ok ? family_total_next : 31'd0;
  end

  // State registers; the final byte returns to the start state
  always_ff @(posedge clk) begin
    if (rst || (fire && end_of_record)) begin
      phase            <= fsrv_pkg::PH_HEADER;
      byte_position    <= 5'd0;
      word_gather      <= 32'd0;
      header_size_code <= 31'd0;
      header_weight    <= 32'd0;
      header_style     <= 1'b0;
      families_left    <= 31'd0;
      family_total     <= 31'd0;
      name_bytes_left  <= 31'd0;
      error_seen       <= 1'b0;
    end else if (fire) begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      word_gather      <= word_gather_next;
      header_size_code <= header_size_code_next;
      header_weight    <= header_weight_next;
      header_style     <= header_style_next;
      families_left    <= families_left_next;
      family_total     <= family_total_next;
      name_bytes_left  <= name_bytes_left_next;
      error_seen       <= error_seen_next;
    end
  end

endmodule

// ===== src/fsrv_out_reg.sv =====
// ----------------------------------------------------------------------------
// fsrv_out_reg
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module fsrv_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  fsrv_pkg::result_t load_data,
  output logic              full,
  input  logic              result_stall,
  output fsrv_pkg::result_t held
);

  logic full_next;

  // Occupancy: a load may replace a result taken in the same cycle
  always_comb begin
    full_next = full;
    if (full && !result_stall) full_next = 1'b0;
    if (load) full_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) held <= load_data;
  end

endmodule

// ===== tb/font_spec_record_validator_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// font_spec_record_validator_core_test
// Self-checking testbench for the byte-serial font spec record validator.
// Records are streamed byte by byte under random bursts and result stalls.
// A predictor inside the bench tracks the parser per accepted byte and
// queues one expected result per final byte. The result monitor compares
// each result transaction field by field.
// ----------------------------------------------------------------------------
module font_spec_record_validator_core_test;

  // Ways a generated record can be broken
  typedef enum logic [2:0] {
    FLAW_NONE,
    FLAW_VERSION,
    FLAW_SIZE_CODE,
    FLAW_STYLE,
    FLAW_COUNT,
    FLAW_NAME_LEN,
    FLAW_TRUNCATE,
    FLAW_TRAILING
  } flaw_t;

  // Result channel back-pressure modes
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  localparam int RANDOM_BYTES = 1100;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        end_of_record = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        valid_res;
  logic [30:0] size_code;
  logic signed [31:0] weight;
  logic        style;
  logic [30:0] num_families;

  font_spec_record_validator_core u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .end_of_record(end_of_record),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .valid_res    (valid_res),
    .size_code    (size_code),
    .weight       (weight),
    .style        (style),
    .num_families (num_families)
  );

  // Clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  int                fail_count = 0;
  int                bytes_sent = 0;
  int                burst_left = 0;
  fsrv_pkg::result_t pending_results[$];
  logic [7:0]        rec_bytes[$];

  // Predictor state
  fsrv_pkg::phase_t rec_phase = fsrv_pkg::PH_HEADER;
  logic [4:0]  rec_pos    = '0;
  logic [31:0] gather_word = '0;
  logic [31:0] key_word   = '0;
  logic [31:0] weight_word = '0;
  logic [31:0] style_word = '0;
  logic [30:0] fam_left   = '0;
  logic [30:0] fam_total  = '0;
  logic [30:0] skip_left  = '0;
  logic        rec_bad    = 1'b0;

  function automatic logic word_is_positive(input logic [31:0] w);
    return (w != 32'd0) && (w[31] == 1'b0);
  endfunction

  function automatic void clear_parser();
    rec_phase   = fsrv_pkg::PH_HEADER;
    rec_pos     = '0;
    gather_word = '0;
    key_word    = '0;
    weight_word = '0;
    style_word  = '0;
    fam_left    = '0;
    fam_total   = '0;
    skip_left   = '0;
    rec_bad     = 1'b0;
  endfunction

  // Advance the parser by one byte; queue a result on the final byte
  function automatic void parse_byte(input logic [7:0] b, input logic last);
    fsrv_pkg::result_t r;
    if (!rec_bad) begin
      if (rec_phase == fsrv_pkg::PH_HEADER || rec_phase == fsrv_pkg::PH_LENGTH)
        gather_word = {b, gather_word[31:8]};
      case (rec_phase)
        fsrv_pkg::PH_HEADER: begin
          rec_pos = rec_pos + 5'd1;
          if (rec_pos[1:0] == 2'd0) begin
            case (rec_pos)
              fsrv_pkg::POS_VERSION: begin
                if (gather_word != fsrv_pkg::SPEC_VERSION) rec_bad = 1'b1;
              end
              fsrv_pkg::POS_SIZE_CODE: begin
                key_word = gather_word;
                if (!word_is_positive(gather_word)) rec_bad = 1'b1;
              end
              fsrv_pkg::POS_WEIGHT: begin
                weight_word = gather_word;
              end
              fsrv_pkg::POS_STYLE: begin
                style_word = gather_word;
                if (gather_word > 32'd1) rec_bad = 1'b1;
              end
              default: begin
                // family count word closes the header
                if (!word_is_positive(gather_word)) begin
                  rec_bad = 1'b1;
                end else begin
                  fam_total = gather_word[30:0];
                  fam_left  = gather_word[30:0];
                  rec_phase = fsrv_pkg::PH_LENGTH;
                  rec_pos   = '0;
                end
              end
            endcase
          end
        end
        fsrv_pkg::PH_LENGTH: begin
          rec_pos = rec_pos + 5'd1;
          if (rec_pos == fsrv_pkg::LENGTH_BYTES) begin
            rec_pos = '0;
            if (!word_is_positive(gather_word)) begin
              rec_bad = 1'b1;
            end else begin
              skip_left = gather_word[30:0];
              rec_phase = fsrv_pkg::PH_NAME;
            end
          end
        end
        fsrv_pkg::PH_NAME: begin
          skip_left = skip_left - 31'd1;
          if (skip_left == 31'd0) begin
            fam_left  = fam_left - 31'd1;
            rec_phase = (fam_left == 31'd0) ? fsrv_pkg::PH_DONE : fsrv_pkg::PH_LENGTH;
          end
        end
        default: begin
          // any byte past the last name
          rec_bad = 1'b1;
        end
      endcase
    end
    if (last) begin
      r = '0;
      if (!rec_bad && rec_phase == fsrv_pkg::PH_DONE) begin
        r.valid_res    = 1'b1;
        r.size_code    = key_word[30:0];
        r.weight       = weight_word;
        r.style        = style_word[0];
        r.num_families = fam_total;
      end
      pending_results.push_back(r);
      clear_parser();
    end
  endfunction

  // Send one byte transaction; bursts with random gaps between them
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        gap = 0;
        burst_left = $urandom_range(40, 120);
      end else begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 32);
      end
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    byte_valid    <= 1'b1;
    data_byte     <= b;
    end_of_record <= last;
    do @(posedge clk); while (byte_stall);
    burst_left--;
    bytes_sent++;
    parse_byte(b, last);
  endtask

  // Stop sending and wait until every queued result has come back
  task automatic wait_results_drained();
    int n;
    n = 0;
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (pending_results.size() != 0) begin
      $error("results still outstanding after drain limit: %0d",
             pending_results.size());
      fail_count++;
    end
  endtask

  // Record assembly helpers
  function automatic void add_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) rec_bytes.push_back(w[8*k +: 8]);
  endfunction

  function automatic void add_random_bytes(input int n);
    for (int k = 0; k < n; k++) rec_bytes.push_back(8'($urandom()));
  endfunction

  function automatic void add_header(input logic [31:0] ver, input logic [31:0] key,
                                     input logic [31:0] wt, input logic [31:0] sty,
                                     input logic [31:0] cnt);
    add_word(ver);
    add_word(key);
    add_word(wt);
    add_word(sty);
    add_word(cnt);
  endfunction

  function automatic void add_family(input logic [31:0] len);
    add_word(len);
    add_random_bytes(int'(len));
  endfunction

  // Stream the assembled record, flagging its final byte
  task automatic send_record();
    for (int i = 0; i < rec_bytes.size(); i++)
      send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
    rec_bytes.delete();
  endtask

  function automatic logic [31:0] bad_positive_word();
    if ($urandom_range(0, 1) == 0) return 32'd0;
    return $urandom() | 32'h8000_0000;
  endfunction

  // Well-formed record with random content, optionally broken one way
  task automatic random_record(input flaw_t flaw);
    logic [31:0] ver, key, wt, sty, len;
    int fam_n, bad_fam, cut;
    ver = fsrv_pkg::SPEC_VERSION;
    key = $urandom() & 32'h7FFF_FFFF;
    if (key == 32'd0 || $urandom_range(0, 9) == 0) key = 32'h7FFF_FFFF;
    if ($urandom_range(0, 9) == 0) key = 32'd1;
    wt = $urandom();
    case ($urandom_range(0, 9))
      0: wt = 32'h8000_0000;
      1: wt = 32'h7FFF_FFFF;
      default: ;
    endcase
    sty = $urandom_range(0, 1);
    fam_n = $urandom_range(1, 3);
    bad_fam = $urandom_range(0, fam_n - 1);
    case (flaw)
      FLAW_VERSION: begin
        ver = $urandom();
        if (ver == fsrv_pkg::SPEC_VERSION) ver = 32'd0;
      end
      FLAW_SIZE_CODE: key = bad_positive_word();
      FLAW_STYLE: begin
        sty = $urandom();
        if (sty < 32'd2) sty = sty + 32'd2;
      end
      default: ;
    endcase
    add_header(ver, key, wt, sty,
               (flaw == FLAW_COUNT) ? bad_positive_word() : 32'(fam_n));
    for (int f = 0; f < fam_n; f++) begin
      if (flaw == FLAW_NAME_LEN && f == bad_fam) begin
        add_word(bad_positive_word());
        add_random_bytes($urandom_range(0, 4));
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        add_family(len);
      end
    end
    if (flaw == FLAW_TRUNCATE) begin
      cut = $urandom_range(1, rec_bytes.size() - 1);
      repeat (cut) void'(rec_bytes.pop_back());
    end
    if (flaw == FLAW_TRAILING) add_random_bytes($urandom_range(1, 4));
    send_record();
  endtask

  // Random bytes with random end flags; half start with a good version word
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 30);
    if ($urandom_range(0, 1) == 0) add_word(fsrv_pkg::SPEC_VERSION);
    add_random_bytes(n);
    for (int i = 0; i < rec_bytes.size(); i++)
      send_byte(rec_bytes[i], (i == rec_bytes.size() - 1) || ($urandom_range(0, 9) == 0));
    rec_bytes.delete();
  endtask

  // ---- Tests ----

  task automatic test_good_records();
    // smallest valid record
    add_header(fsrv_pkg::SPEC_VERSION, 32'd1, 32'd0, 32'd0, 32'd1);
    add_family(32'd1);
    send_record();
    // field extremes
    add_header(fsrv_pkg::SPEC_VERSION, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd2);
    add_family(32'd1);
    add_family(32'd3);
    send_record();
    add_header(fsrv_pkg::SPEC_VERSION, 32'h4000_0000, 32'hFFFF_FFFF, 32'd0, 32'd1);
    add_family(32'd2);
    send_record();
  endtask

  task automatic test_header_checks();
    // bad version, rest of the record ignored
    add_word(32'd0);
    add_random_bytes(2);
    send_record();
    add_word(32'h0000_0101);
    send_record();
    // size code zero and negative
    add_header(fsrv_pkg::SPEC_VERSION, 32'd0, 32'd5, 32'd0, 32'd1);
    send_record();
    add_word(fsrv_pkg::SPEC_VERSION);
    add_word(32'h8000_0000);
    add_random_bytes(1);
    send_record();
    // style out of range
    add_header(fsrv_pkg::SPEC_VERSION, 32'd9, 32'd0, 32'd2, 32'd1);
    add_family(32'd1);
    send_record();
    add_header(fsrv_pkg::SPEC_VERSION, 32'd9, 32'd0, 32'hFFFF_FFFF, 32'd1);
    send_record();
    // family count zero and negative
    add_header(fsrv_pkg::SPEC_VERSION, 32'd3, 32'd0, 32'd1, 32'd0);
    send_record();
    add_header(fsrv_pkg::SPEC_VERSION, 32'd3, 32'd0, 32'd1, 32'h8000_0000);
    add_random_bytes(2);
    send_record();
  endtask

  task automatic test_short_record();
    add_random_bytes(1);
    send_record();
    add_header(fsrv_pkg::SPEC_VERSION, 32'd1, 32'd1, 32'd0, 32'd1);
    void'(rec_bytes.pop_back());
    send_record();
    // header only, no family entries
    add_header(fsrv_pkg::SPEC_VERSION, 32'd1, 32'd1, 32'd0, 32'd1);
    send_record();
  endtask

  task automatic test_name_lengths();
    add_header(fsrv_pkg::SPEC_VERSION, 32'd7, 32'd1, 32'd0, 32'd1);
    add_word(32'd0);
    send_record();
    add_header(fsrv_pkg::SPEC_VERSION, 32'd7, 32'd1, 32'd0, 32'd2);
    add_family(32'd1);
    add_word(32'h8000_0000);
    add_random_bytes(1);
    send_record();
    add_header(fsrv_pkg::SPEC_VERSION, 32'd7, 32'd1, 32'd0, 32'd1);
    add_word(32'hFFFF_FFFF);
    send_record();
  endtask

  task automatic test_early_end();
    // inside a length word
    add_header(fsrv_pkg::SPEC_VERSION, 32'd2, 32'd0, 32'd0, 32'd1);
    add_random_bytes(2);
    send_record();
    // inside a name
    add_header(fsrv_pkg::SPEC_VERSION, 32'd2, 32'd0, 32'd0, 32'd1);
    add_word(32'd5);
    add_random_bytes(3);
    send_record();
    // before all families
    add_header(fsrv_pkg::SPEC_VERSION, 32'd2, 32'd0, 32'd1, 32'd2);
    add_family(32'd2);
    send_record();
    // largest counts leave the record far from complete
    add_header(fsrv_pkg::SPEC_VERSION, 32'd2, 32'd0, 32'd0, 32'd1);
    add_word(32'h7FFF_FFFF);
    add_random_bytes(4);
    send_record();
    add_header(fsrv_pkg::SPEC_VERSION, 32'd2, 32'd0, 32'd0, 32'h7FFF_FFFF);
    add_family(32'd1);
    send_record();
  endtask

  task automatic test_trailing_bytes();
    add_header(fsrv_pkg::SPEC_VERSION, 32'd11, 32'd4, 32'd1, 32'd1);
    add_family(32'd2);
    add_random_bytes(1);
    send_record();
    add_header(fsrv_pkg::SPEC_VERSION, 32'd11, 32'd4, 32'd0, 32'd1);
    add_family(32'd1);
    add_random_bytes(3);
    send_record();
  endtask

  task automatic test_random_records();
    int start;
    int sel;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) random_record(FLAW_NONE);
      else if (sel < 85) random_record(flaw_t'($urandom_range(1, 7)));
      else send_noise();
    end
  endtask

  // ---- Result monitor ----

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  stall_mode_t stall_mode = STALL_NONE;
  int          stall_mode_left = 0;
  int          stall_tick = 0;

  initial begin
    fsrv_pkg::result_t want;
    forever begin
      @(posedge clk);
      // check a result transaction accepted at this edge
      if (!rst && result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transaction: valid_res %0b", valid_res);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("valid_res", 32'(want.valid_res), 32'(valid_res));
          check_field("size_code", 32'(want.size_code), 32'(size_code));
          check_field("weight", want.weight, weight);
          check_field("style", 32'(want.style), 32'(style));
          check_field("num_families", 32'(want.num_families), 32'(num_families));
        end
      end
      // back-pressure pattern
      if (stall_mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_mode_left = $urandom_range(20, 200);
      end
      stall_mode_left--;
      stall_tick++;
      case (stall_mode)
        STALL_NONE:     result_stall <= 1'b0;
        STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    result_stall <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: result_stall <= ((stall_tick % 8) < 5);
        default:        result_stall <= 1'b0;
      endcase
    end
  end

  // ---- Sequence ----

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_good_records();
    test_header_checks();
    test_short_record();
    test_name_lengths();
    test_early_end();
    test_trailing_bytes();
    // hold the sender until the pipeline is empty
    wait_results_drained();
    test_random_records();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
